// File: rtl/vgds_pkg.sv
// ----------------------------------------------------------------------------
// vgds_pkg
// Shared widths, register codes, word types and arithmetic step functions
// for the voxel gradient diffuse shading core.
// ----------------------------------------------------------------------------
package vgds_pkg;

  localparam int COORD_W    = 7;
  localparam int DEN_W      = 8;
  localparam int LIGHT_W    = 20;
  localparam int INT_W      = 8;
  localparam int THR_W      = 16;
  localparam int SHADE_W    = 8;
  localparam int CIDX_W     = 3;
  localparam int CDATA_W    = 20;

  // light vector magnitude, sums of squares, square root, divider
  localparam int LMAG_W     = 20;
  localparam int LS_W       = 42;
  localparam int GS_W       = 18;
  localparam int ROOT_W     = 21;
  localparam int SREM_W     = 22;
  localparam int DREM_W     = 21;
  localparam int Q_W        = 16;
  localparam int SQ_STEPS   = 21;
  localparam int DIV_STEPS  = 16;
  localparam int LANES      = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [CIDX_W-1:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_INTENSITY = 3'd3,
    REG_THRESHOLD = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] light_x;
    logic [LIGHT_W-1:0] light_y;
    logic [LIGHT_W-1:0] light_z;
    logic [INT_W-1:0]   intensity;
    logic [THR_W-1:0]   threshold;
  } cfg_t;

  // word passed from the front end to the back end through the queue
  typedef struct packed {
    logic [2:0]             lsgn;
    logic [2:0][LMAG_W-1:0] lmag;
    logic [2:0]             gsgn;
    logic [2:0][DEN_W-1:0]  gmag;
    logic [LS_W-1:0]        ls;
    logic [GS_W-1:0]        gs;
    logic                   lit;
  } item_t;

  typedef struct packed {
    logic [LS_W-1:0]   s;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [Q_W-1:0]    q;
  } dv_t;

  // One digit of the integer square root: bring in two bits, try 4r+1.
  function automatic sq_t sqrt_step(sq_t a);
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] trial;
    sq_t               b;
    t     = {a.rem, a.s[LS_W-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    b.s   = {a.s[LS_W-3:0], 2'b00};
    if (t >= trial) begin
      b.rem  = SREM_W'(t - trial);
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = t[SREM_W-1:0];
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  // One quotient bit of a restoring divide.
  function automatic dv_t div_step(dv_t a, logic [DREM_W:0] t, logic [ROOT_W-1:0] r);
    dv_t b;
    if (t >= {1'b0, r}) begin
      b.rem = DREM_W'(t - {1'b0, r});
      b.q   = {a.q[Q_W-2:0], 1'b1};
    end else begin
      b.rem = t[DREM_W-1:0];
      b.q   = {a.q[Q_W-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

// File: rtl/vgds_front.sv
// ----------------------------------------------------------------------------
// vgds_front
// Accepts voxel words, forms the light and gradient vectors, their sums of
// squares and the threshold decision, and hands each word to the queue.
// ----------------------------------------------------------------------------
module vgds_front import vgds_pkg::*; #(
  parameter int VOLUME_DIM = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] voxel_x,
  input  logic [COORD_W-1:0] voxel_y,
  input  logic [COORD_W-1:0] voxel_z,
  input  logic [DEN_W-1:0]   center_density,
  input  logic [DEN_W-1:0]   next_x_density,
  input  logic [DEN_W-1:0]   next_y_density,
  input  logic [DEN_W-1:0]   next_z_density,
  output logic               push,
  input  logic               queue_full,
  output item_t              item
);

  localparam int COORD_TOP = (1 << COORD_W) - 1;
  localparam int CMAX      = (VOLUME_DIM - 1 > COORD_TOP) ? COORD_TOP : VOLUME_DIM - 1;
  localparam logic [COORD_W-1:0] CMAX_V = COORD_W'(CMAX);

  logic fen;

  logic                   f1v;
  logic [2:0]             l1_sgn;
  logic [2:0][LMAG_W-1:0] l1_mag;
  logic [2:0]             g1_sgn;
  logic [2:0][DEN_W-1:0]  g1_mag;

  logic                     f2v;
  logic [2:0]               l2_sgn;
  logic [2:0][LMAG_W-1:0]   l2_mag;
  logic [2:0]               g2_sgn;
  logic [2:0][DEN_W-1:0]    g2_mag;
  logic [2:0][2*LMAG_W-1:0] l2_sq;
  logic [2:0][2*DEN_W-1:0]  g2_sq;
  logic [2*THR_W-1:0]       thr2;

  logic f3v;

  logic [2:0][COORD_W-1:0] crd;
  logic [2:0][LIGHT_W-1:0] lpos;
  logic [2:0][DEN_W-1:0]   nden;
  logic [2:0]              l_sgn_c;
  logic [2:0][LMAG_W-1:0]  l_mag_c;
  logic [2:0]              g_sgn_c;
  logic [2:0][DEN_W-1:0]   g_mag_c;
  logic [LS_W-1:0]         ls_c;
  logic [GS_W-1:0]         gs_c;

  // advance the whole front end unless a finished word waits on a full queue
  assign fen      = !f3v || !queue_full;
  assign in_ready = fen;
  assign push     = f3v && !queue_full;

  // saturate coordinates and form the difference vectors
  always_comb begin
    logic [LIGHT_W+1:0] ld;
    logic [LIGHT_W+1:0] la;
    logic [DEN_W:0]     gd;
    logic [DEN_W:0]     ga;
    crd[0]  = (voxel_x > CMAX_V) ? CMAX_V : voxel_x;
    crd[1]  = (voxel_y > CMAX_V) ? CMAX_V : voxel_y;
    crd[2]  = (voxel_z > CMAX_V) ? CMAX_V : voxel_z;
    lpos[0] = cfg.light_x;
    lpos[1] = cfg.light_y;
    lpos[2] = cfg.light_z;
    nden[0] = next_x_density;
    nden[1] = next_y_density;
    nden[2] = next_z_density;
    for (int i = 0; i < 3; i++) begin
      ld = {{2{lpos[i][LIGHT_W-1]}}, lpos[i]} - {7'd0, crd[i], 8'd0};
      la = ld[LIGHT_W+1] ? (~ld + 1'b1) : ld;
      l_sgn_c[i] = ld[LIGHT_W+1];
      l_mag_c[i] = la[LMAG_W-1:0];
      gd = {1'b0, nden[i]} - {1'b0, center_density};
      ga = gd[DEN_W] ? (~gd + 1'b1) : gd;
      g_sgn_c[i] = gd[DEN_W];
      g_mag_c[i] = ga[DEN_W-1:0];
    end
  end

  // sum the squares of the registered products
  always_comb begin
    ls_c = LS_W'(l2_sq[0]) + LS_W'(l2_sq[1]) + LS_W'(l2_sq[2]);
    gs_c = GS_W'(g2_sq[0]) + GS_W'(g2_sq[1]) + GS_W'(g2_sq[2]);
  end

  // hold stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
      f2v <= 1'b0;
      f3v <= 1'b0;
    end else if (fen) begin
      f1v <= in_valid;
      f2v <= f1v;
      f3v <= f2v;
    end
  end

  // advance stage payloads
  always_ff @(posedge clk) begin
    if (fen) begin
      l1_sgn <= l_sgn_c;
      l1_mag <= l_mag_c;
      g1_sgn <= g_sgn_c;
      g1_mag <= g_mag_c;

      l2_sgn <= l1_sgn;
      l2_mag <= l1_mag;
      g2_sgn <= g1_sgn;
      g2_mag <= g1_mag;
      for (int i = 0; i < 3; i++) begin
        l2_sq[i] <= l1_mag[i] * l1_mag[i];
        g2_sq[i] <= g1_mag[i] * g1_mag[i];
      end
      thr2 <= cfg.threshold * cfg.threshold;

      item.lsgn <= l2_sgn;
      item.lmag <= l2_mag;
      item.gsgn <= g2_sgn;
      item.gmag <= g2_mag;
      item.ls   <= ls_c;
      item.gs   <= gs_c;
      item.lit  <= ({gs_c, 16'd0} >= {2'd0, thr2});
    end
  end

endmodule

// File: rtl/vgds_fifo.sv
// ----------------------------------------------------------------------------
// vgds_fifo
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module vgds_fifo import vgds_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  empty
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rptr];

  // move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // store words
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

endmodule

// File: rtl/vgds_back.sv
// ----------------------------------------------------------------------------
// vgds_back
// Square roots, unit vector divides, dot product and shade for each word
// taken from the queue; stalls as one when the output word is not taken.
// ----------------------------------------------------------------------------
module vgds_back import vgds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [INT_W-1:0]   intensity,
  input  logic               queue_empty,
  input  item_t              queue_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SHADE_W-1:0] shade
);

  typedef struct packed {
    logic [LANES-1:0]             sgn;
    logic [LANES-1:0][LMAG_W-1:0] mag;
    logic                         lit;
  } pay_t;

  localparam dv_t DV_ZERO = '0;
  localparam logic [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic [Q_W-1:0] DOT_MAX = Q_W'(32768);

  logic ben;

  // square root section
  logic sv  [SQ_STEPS+1];
  pay_t sp  [SQ_STEPS+1];
  sq_t  sql [SQ_STEPS+1];
  sq_t  sqg [SQ_STEPS+1];
  pay_t p0;

  // divide section
  logic              dvv  [1:DIV_STEPS];
  logic [LANES-1:0]  dsgn [1:DIV_STEPS];
  logic              dlit [1:DIV_STEPS];
  logic [ROOT_W-1:0] drl  [1:DIV_STEPS];
  logic [ROOT_W-1:0] drg  [1:DIV_STEPS];
  dv_t               dv   [1:DIV_STEPS][LANES];

  // unit vectors, products, dot
  logic signed [Q_W-1:0]  u [LANES];
  logic                   pv;
  logic                   plit;
  logic signed [30:0]     prd [3];
  logic                   tv;
  logic                   tlit;
  logic [Q_W-1:0]         dot;
  logic [Q_W-1:0]         dot_c;
  logic [SHADE_W-1:0]     shade_c;

  assign ben = !out_valid || out_ready;
  assign pop = ben && !queue_empty;

  // spread the queue word over six lanes: light first, gradient after
  always_comb begin
    p0.sgn = {queue_item.gsgn, queue_item.lsgn};
    p0.lit = queue_item.lit;
    for (int i = 0; i < 3; i++) begin
      p0.mag[i]     = queue_item.lmag[i];
      p0.mag[i + 3] = LMAG_W'(queue_item.gmag[i]);
    end
  end

  // saturate quotients and apply signs; a zero root gives a zero vector
  always_comb begin
    logic [Q_W-1:0] qs;
    logic           zero;
    for (int i = 0; i < LANES; i++) begin
      zero = (i < 3) ? (drl[DIV_STEPS] == '0) : (drg[DIV_STEPS] == '0);
      qs   = (dv[DIV_STEPS][i].q > Q_MAX) ? Q_MAX : dv[DIV_STEPS][i].q;
      if (zero)                  u[i] = '0;
      else if (dsgn[DIV_STEPS][i]) u[i] = $signed(~qs + 1'b1);
      else                       u[i] = $signed(qs);
    end
  end

  // sum products, drop the back side, scale and clamp
  always_comb begin
    logic signed [32:0] acc;
    logic [17:0]        dq;
    logic [INT_W+Q_W-1:0] sc;
    acc = 33'(prd[0]) + 33'(prd[1]) + 33'(prd[2]);
    dq  = acc[32:15];
    if (acc[32])               dot_c = '0;
    else if (dq > 18'(DOT_MAX)) dot_c = DOT_MAX;
    else                       dot_c = dq[Q_W-1:0];
    sc = intensity * dot;
    if (!tlit)                 shade_c = '0;
    else if (sc[INT_W+Q_W-1:15] > 9'd255) shade_c = 8'd255;
    else                       shade_c = sc[22:15];
  end

  // hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STEPS; k++) sv[k] <= 1'b0;
      for (int k = 1; k <= DIV_STEPS; k++) dvv[k] <= 1'b0;
      pv        <= 1'b0;
      tv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ben) begin
      sv[0] <= !queue_empty;
      for (int k = 1; k <= SQ_STEPS; k++) sv[k] <= sv[k-1];
      dvv[1] <= sv[SQ_STEPS];
      for (int k = 2; k <= DIV_STEPS; k++) dvv[k] <= dvv[k-1];
      pv        <= dvv[DIV_STEPS];
      tv        <= pv;
      out_valid <= tv;
    end
  end

  // advance payloads
  always_ff @(posedge clk) begin
    if (ben) begin
      sp[0]  <= p0;
      sql[0] <= '{s: queue_item.ls, rem: '0, root: '0};
      sqg[0] <= '{s: LS_W'(queue_item.gs), rem: '0, root: '0};
      for (int k = 1; k <= SQ_STEPS; k++) begin
        sp[k]  <= sp[k-1];
        sql[k] <= sqrt_step(sql[k-1]);
        sqg[k] <= sqrt_step(sqg[k-1]);
      end

      dsgn[1] <= sp[SQ_STEPS].sgn;
      dlit[1] <= sp[SQ_STEPS].lit;
      drl[1]  <= sql[SQ_STEPS].root;
      drg[1]  <= sqg[SQ_STEPS].root;
      for (int i = 0; i < LANES; i++) begin
        dv[1][i] <= div_step(DV_ZERO, (DREM_W+1)'(sp[SQ_STEPS].mag[i]),
                             (i < 3) ? sql[SQ_STEPS].root : sqg[SQ_STEPS].root);
      end
      for (int k = 2; k <= DIV_STEPS; k++) begin
        dsgn[k] <= dsgn[k-1];
        dlit[k] <= dlit[k-1];
        drl[k]  <= drl[k-1];
        drg[k]  <= drg[k-1];
        for (int i = 0; i < LANES; i++) begin
          dv[k][i] <= div_step(dv[k-1][i], {dv[k-1][i].rem, 1'b0},
                               (i < 3) ? drl[k-1] : drg[k-1]);
        end
      end

      plit <= dlit[DIV_STEPS];
      // widen both unit components so the full product is kept
      for (int i = 0; i < 3; i++) prd[i] <= 31'(32'(u[i]) * 32'(u[i + 3]));
      tlit  <= plit;
      dot   <= dot_c;
      shade <= shade_c;
    end
  end

endmodule

// File: rtl/voxel_gradient_diffuse_shading_core.sv
// ----------------------------------------------------------------------------
// voxel_gradient_diffuse_shading_core
// Diffuse shading of streamed voxels under a point light.
// ----------------------------------------------------------------------------
// Channel  Role    Handshake              Payload
// in       sink    in_valid / in_ready    voxel_x/y/z, center/next_*_density
// out      source  out_valid / out_ready  shade
// cfg      sink    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while the output is taken; the back end holds
// a 21-digit square root and a 16-bit divide pipeline.
// Reset clears all valid state and loads register defaults; cfg_ready is
// always high. An output stall freezes the back pipeline; the front end keeps
// accepting until its 4-word queue is full and its last stage holds a word.
// ----------------------------------------------------------------------------
module voxel_gradient_diffuse_shading_core import vgds_pkg::*; #(
  parameter int VOLUME_DIM = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] voxel_x,
  input  logic [COORD_W-1:0] voxel_y,
  input  logic [COORD_W-1:0] voxel_z,
  input  logic [DEN_W-1:0]   center_density,
  input  logic [DEN_W-1:0]   next_x_density,
  input  logic [DEN_W-1:0]   next_y_density,
  input  logic [DEN_W-1:0]   next_z_density,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SHADE_W-1:0] shade
);

  cfg_t  cfg;
  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_empty;
  item_t front_item;
  item_t back_item;

  assign cfg_ready = 1'b1;

  // write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_x   <= '0;
      cfg.light_y   <= '0;
      cfg.light_z   <= '0;
      cfg.intensity <= INT_W'(255);
      cfg.threshold <= THR_W'(3);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LIGHT_X:   cfg.light_x   <= cfg_data;
        REG_LIGHT_Y:   cfg.light_y   <= cfg_data;
        REG_LIGHT_Z:   cfg.light_z   <= cfg_data;
        REG_INTENSITY: cfg.intensity <= cfg_data[INT_W-1:0];
        REG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  vgds_front #(
    .VOLUME_DIM(VOLUME_DIM)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .voxel_x        (voxel_x),
    .voxel_y        (voxel_y),
    .voxel_z        (voxel_z),
    .center_density (center_density),
    .next_x_density (next_x_density),
    .next_y_density (next_y_density),
    .next_z_density (next_z_density),
    .push           (push),
    .queue_full     (queue_full),
    .item           (front_item)
  );

  vgds_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (back_item),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  vgds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .intensity   (cfg.intensity),
    .queue_empty (queue_empty),
    .queue_item  (back_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shade       (shade)
  );

endmodule

// File: rtl/vgds_checker.sv
// ----------------------------------------------------------------------------
// vgds_checker
// Port-level checks on the shading core, attached by bind.
// ----------------------------------------------------------------------------
module vgds_checker import vgds_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SHADE_W-1:0] shade
);

  logic [7:0] inflight;

  // count words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shade))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 8'd0)
    else $error("output word with nothing in flight");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    inflight == 8'd0 |-> in_ready)
    else $error("input not ready while empty");

  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind voxel_gradient_diffuse_shading_core vgds_checker u_vgds_checker (.*);
